// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define NTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define NTC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define NTC_ASSERT(lbl, clk, rst, prop)
`define NTC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// File: rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Widths, constants, resistance tables and handshake types of the
// thermistor code to temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int CODE_W         = 12;
   localparam int TEMP_W         = 12;
   localparam int ADC_FULL_SCALE = 4095;
   localparam int BIAS_OHMS      = 10000;

   // divider: dividend holds 10000*code and (R-p0)<<8, divisor holds
   // full_scale-code and p1-p0
   localparam int DIV_W  = 26;
   localparam int DVS_W  = 17;
   localparam int CNT_W  = $clog2(DIV_W + 1);

   localparam int ROM_LEN = 34;
   localparam int IDX_W   = $clog2(ROM_LEN);
   localparam int OHM_W   = 19;

   localparam int T_FIRST = 1250;
   localparam int T_LAST  = -400;
   localparam int T_STEP  = 50;
   localparam int FRAC_W  = 8;
   localparam int ALPHA_W = FRAC_W + 1;
   localparam int SCALE_W = ALPHA_W + 6;

   typedef logic [OHM_W-1:0] ohm_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   localparam ohm_type ROM_B3435 [ROM_LEN] = '{
      19'd531,    19'd596,    19'd672,    19'd758,    19'd858,    19'd974,
      19'd1110,   19'd1268,   19'd1452,   19'd1669,   19'd1925,   19'd2228,
      19'd2586,   19'd3014,   19'd3535,   19'd4161,   19'd4917,   19'd5834,
      19'd6948,   19'd8315,   19'd10000,  19'd12081,  19'd14674,  19'd17926,
      19'd22021,  19'd27219,  19'd33892,  19'd42506,  19'd53650,  19'd68237,
      19'd87559,  19'd113347, 19'd148171, 19'd195652
   };

   localparam ohm_type ROM_B3977 [ROM_LEN] = '{
      19'd351,    19'd398,    19'd454,    19'd519,    19'd595,    19'd685,
      19'd792,    19'd919,    19'd1070,   19'd1253,   19'd1472,   19'd1739,
      19'd2064,   19'd2463,   19'd2954,   19'd3563,   19'd4323,   19'd5279,
      19'd6486,   19'd8025,   19'd10000,  19'd12555,  19'd15887,  19'd20272,
      19'd26094,  19'd33900,  19'd44474,  19'd58952,  19'd78999,  19'd107095,
      19'd146974, 19'd204347, 19'd288075, 19'd412135
   };

   // resistance at table index; entries run from 125.0 down to -40.0 degC
   function automatic ohm_type rom_ohms(input logic sel, input logic [IDX_W-1:0] idx);
      ohm_type val;
      val = '0;
      if (idx < IDX_W'(ROM_LEN)) begin
         case (sel)
            1'b0:    val = ROM_B3435[idx];
            default: val = ROM_B3977[idx];
         endcase
      end
      return val;
   endfunction

endpackage

// File: rtl/ntc_serial_div.sv
// ----------------------------------------------------------------------------
// ntc_serial_div
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ntc_serial_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ntc_pkg::div_req_type div_req,
   output ntc_pkg::div_rsp_type div_rsp
);

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [ntc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ntc_pkg::DIV_W-1:0]  dvd_ff, dvd_in;
   logic [ntc_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [ntc_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [ntc_pkg::DVS_W:0]    shifted;
   logic [ntc_pkg::DVS_W:0]    diff;
   logic                       ge;

   // remainder stays below the divisor, so the shifted value is below twice it
   assign shifted = {rem_ff, dvd_ff[ntc_pkg::DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = ~diff[ntc_pkg::DVS_W];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = div_req.dividend;
         dvs_in = div_req.divisor;
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = ge ? diff[ntc_pkg::DVS_W-1:0] : shifted[ntc_pkg::DVS_W-1:0];
         dvd_in = {dvd_ff[ntc_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ntc_pkg::CNT_W'(ntc_pkg::DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// File: rtl/ntc_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// Thermistor divider ADC code to temperature in tenths of a degree Celsius:
// resistance by serial division, table walk, interpolation by serial division.
// ----------------------------------------------------------------------------
//   channel   ports                              handshake
//   request   start, busy, req_adc_code          taken when start && !busy
//   response  rsp_valid, rsp_temperature_tenths  one-cycle strobe, no stall
//   csr       csr_write_enable, csr_write_data   written on enable
//
// A full-scale code answers in the cycle after it is accepted. Otherwise the
// resistance divide runs first; out-of-table resistances answer right after it.
// In range, the table walk follows and then the fraction divide, after which
// the result is issued.
// Synchronous active-high reset; the curve select register resets to curve 0.
// The receiver cannot stall; busy stays high until the result is issued.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntc_adc_to_temperature (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ntc_pkg::CODE_W-1:0]          req_adc_code,
   output logic                                rsp_valid,
   output logic signed [ntc_pkg::TEMP_W-1:0]   rsp_temperature_tenths,
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIV1   = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_DIV2   = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic                              curve_ff, curve_in;
   logic [ntc_pkg::DIV_W-1:0]         ohms_ff, ohms_in;
   logic [ntc_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic signed [ntc_pkg::TEMP_W-1:0] result_ff, result_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   ntc_pkg::div_req_type              div_req;
   ntc_pkg::div_rsp_type              div_rsp;

   logic                              accept;
   logic                              full_scale;
   ntc_pkg::ohm_type                  tab_lo, tab_hi, tab_cur, tab_nxt;
   logic [ntc_pkg::ALPHA_W-1:0]       alpha;
   logic [ntc_pkg::SCALE_W-1:0]       scaled;
   logic [ntc_pkg::SCALE_W-ntc_pkg::FRAC_W-1:0] drop;

   ntc_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept     = start && (state_ff == S_IDLE);
   assign full_scale = ntc_pkg::DVS_W'(req_adc_code) >= ntc_pkg::DVS_W'(ntc_pkg::ADC_FULL_SCALE);

   assign tab_lo  = ntc_pkg::rom_ohms(curve_ff, '0);
   assign tab_hi  = ntc_pkg::rom_ohms(curve_ff, ntc_pkg::IDX_W'(ntc_pkg::ROM_LEN - 1));
   assign tab_cur = ntc_pkg::rom_ohms(curve_ff, idx_ff);
   assign tab_nxt = ntc_pkg::rom_ohms(curve_ff, idx_ff + 1'b1);

   // floor of -alpha*50/256, taken as a ceiling on the magnitude
   assign alpha  = div_rsp.quotient[ntc_pkg::ALPHA_W-1:0];
   assign scaled = ntc_pkg::SCALE_W'(alpha) * ntc_pkg::SCALE_W'(ntc_pkg::T_STEP)
                 + ntc_pkg::SCALE_W'((1 << ntc_pkg::FRAC_W) - 1);
   assign drop   = scaled[ntc_pkg::SCALE_W-1:ntc_pkg::FRAC_W];

   always_comb begin
      state_in         = state_ff;
      curve_in         = curve_ff;
      ohms_in          = ohms_ff;
      idx_in           = idx_ff;
      result_in        = result_ff;
      rsp_valid_in     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = ntc_pkg::DIV_W'(ntc_pkg::BIAS_OHMS * req_adc_code);
      div_req.divisor  = ntc_pkg::DVS_W'(ntc_pkg::ADC_FULL_SCALE)
                       - ntc_pkg::DVS_W'(req_adc_code);

      if (csr_write_enable) begin
         curve_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (full_scale) begin
                  result_in    = ntc_pkg::TEMP_W'(ntc_pkg::T_LAST);
                  rsp_valid_in = 1'b1;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               ohms_in = div_rsp.quotient;
               idx_in  = '0;
               if (div_rsp.quotient < ntc_pkg::DIV_W'(tab_lo)) begin
                  result_in    = ntc_pkg::TEMP_W'(ntc_pkg::T_FIRST);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (div_rsp.quotient > ntc_pkg::DIV_W'(tab_hi)) begin
                  result_in    = ntc_pkg::TEMP_W'(ntc_pkg::T_LAST);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            // walk up until the next entry is not below the resistance
            if (idx_ff < ntc_pkg::IDX_W'(ntc_pkg::ROM_LEN - 2)
                && ohms_ff > ntc_pkg::DIV_W'(tab_nxt)) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = (ohms_ff - ntc_pkg::DIV_W'(tab_cur)) << ntc_pkg::FRAC_W;
               div_req.divisor  = ntc_pkg::DVS_W'(tab_nxt - tab_cur);
               state_in         = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               result_in = ntc_pkg::TEMP_W'(ntc_pkg::T_FIRST)
                         - ntc_pkg::TEMP_W'(idx_ff * ntc_pkg::T_STEP)
                         - ntc_pkg::TEMP_W'(drop);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         curve_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         curve_ff     <= curve_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ohms_ff   <= ohms_in;
      idx_ff    <= idx_in;
      result_ff <= result_in;
   end

   assign busy                   = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_tenths = result_ff;

   `NTC_ASSERT(a_accept_progress, clock, reset, (start && !busy) |=> (busy || rsp_valid))
   `NTC_ASSERT_NEVER(a_rsp_while_busy, clock, reset, rsp_valid && busy)
   `NTC_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> (rsp_temperature_tenths >= -12'sd400 && rsp_temperature_tenths <= 12'sd1250))
   `NTC_ASSERT(a_div_done_state, clock, reset, div_rsp.done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))

endmodule
